// File: hdl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types, register indexes, mode codes and counter helpers for the
// tournament (gshare / bimodal / chooser) branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package hbp_pkg;

  // Default table sizes (index bits) for the counter memories
  localparam int MAX_GSHARE_BITS_DEF  = 14;
  localparam int MAX_BIMODAL_BITS_DEF = 14;
  localparam int MAX_CHOOSER_BITS_DEF = 14;

  // Stored global history length
  localparam int HIST_W = 14;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  // Clamped index-bit counts (up to 15) fit in this width
  localparam int NBITS_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GSHARE_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIMODAL_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOOSER_BITS = 3'd4;

  // Predictor modes; the unused code behaves as hybrid
  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] GSHARE_BITS_RST  = 4'd12;
  localparam logic [CFG_DATA_W-1:0] HISTORY_BITS_RST = 4'd8;
  localparam logic [CFG_DATA_W-1:0] BIMODAL_BITS_RST = 4'd12;
  localparam logic [CFG_DATA_W-1:0] CHOOSER_BITS_RST = 4'd10;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MAX          = 2'd3;
  localparam ctr_t CTR_MIN          = 2'd0;
  localparam ctr_t PRED_CTR_INIT    = 2'd2;
  localparam ctr_t CHOOSER_CTR_INIT = 2'd1;

  // Saturating 2-bit counter step
  function automatic ctr_t sat_bump(ctr_t c, logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

  // Clamp a configured bit count to a table maximum
  function automatic logic [NBITS_W-1:0] clamp_bits(logic [NBITS_W-1:0] v,
                                                   logic [NBITS_W-1:0] maxv);
    return (v > maxv) ? maxv : v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hybrid_branch_predictor_unit.sv
// ----------------------------------------------------------------------------
// hybrid_branch_predictor_unit
// Tournament branch predictor: bimodal and gshare 2-bit counter tables with a
// chooser table, each in a synchronous memory updated by read-modify-write.
// ----------------------------------------------------------------------------
//  channel | ports                                   | dir | meaning
//  --------+-----------------------------------------+-----+-----------------------
//  in      | in_valid, in_stall, in_pc, in_branch_taken | in  | resolved branch
//  out     | out_valid, out_stall, out_predicted_taken, | out | prediction, mispredict
//          | out_mispredicted                        |     |
//  cfg     | cfg_we, cfg_index, cfg_wdata            | in  | register write
//
//  One transaction per cycle unless in_stall is high; the memory read data and
//  stage 1 registers load at acceptance, and the output register loads from
//  stage 1 when stage 1 can advance, raising out_valid.
//  The counter memory read-modify-write sets the rate; a read of an entry
//  written by the previous transaction is forwarded from the write register.
//  After reset a clearing pass writes one entry a cycle into all three tables,
//  over 2^max(table bits) addresses (16384 by default) with in_stall high.
//  A stall on the output holds the pending transaction and back-pressures in.
// ----------------------------------------------------------------------------
`default_nettype none

module hybrid_branch_predictor_unit #(
  parameter int MAX_GSHARE_BITS  = hbp_pkg::MAX_GSHARE_BITS_DEF,
  parameter int MAX_BIMODAL_BITS = hbp_pkg::MAX_BIMODAL_BITS_DEF,
  parameter int MAX_CHOOSER_BITS = hbp_pkg::MAX_CHOOSER_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // branch input
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      in_pc,
  input  wire logic                             in_branch_taken,
  // prediction result
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_predicted_taken,
  output logic                                  out_mispredicted,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [hbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hbp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int GW    = MAX_GSHARE_BITS;
  localparam int BW    = MAX_BIMODAL_BITS;
  localparam int CW    = MAX_CHOOSER_BITS;
  localparam int HW    = hbp_pkg::HIST_W;
  localparam int NW    = hbp_pkg::NBITS_W;
  localparam int HX_W  = (GW > HW) ? GW : HW;
  localparam int CLR_W = (GW > BW) ? ((GW > CW) ? GW : CW) : ((BW > CW) ? BW : CW);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]                          mode_r;
  logic [hbp_pkg::CFG_DATA_W-1:0]      gbits_r, hbits_r, bbits_r, cbits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= hbp_pkg::MODE_BIMODAL;
      gbits_r <= hbp_pkg::GSHARE_BITS_RST;
      hbits_r <= hbp_pkg::HISTORY_BITS_RST;
      bbits_r <= hbp_pkg::BIMODAL_BITS_RST;
      cbits_r <= hbp_pkg::CHOOSER_BITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbp_pkg::CFG_MODE:         mode_r  <= cfg_wdata[1:0];
        hbp_pkg::CFG_GSHARE_BITS:  gbits_r <= cfg_wdata;
        hbp_pkg::CFG_HISTORY_BITS: hbits_r <= cfg_wdata;
        hbp_pkg::CFG_BIMODAL_BITS: bbits_r <= cfg_wdata;
        hbp_pkg::CFG_CHOOSER_BITS: cbits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic             clr_busy_r;
  logic [CLR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clr_busy_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic in_acc;
  logic s1_valid_r;
  logic s1_adv;
  logic s1_fire;
  logic out_valid_r;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Index computation at acceptance
  // --------------------------------------------------------------------------
  logic [NW-1:0]   m_bits, n_bits, mb_bits, k_bits, sh_amt;
  logic [29:0]     word;
  logic [HW-1:0]   hist_r;
  logic [HW-1:0]   hist_mask, hist_cur, hist_new, hist_shift;
  logic [HX_W-1:0] hist_ext;
  logic [GW-1:0]   gi;
  logic [BW-1:0]   bi;
  logic [CW-1:0]   ci;

  always_comb begin
    m_bits  = hbp_pkg::clamp_bits({1'b0, gbits_r}, NW'(MAX_GSHARE_BITS));
    n_bits  = hbp_pkg::clamp_bits({1'b0, hbits_r}, m_bits);
    mb_bits = hbp_pkg::clamp_bits({1'b0, bbits_r}, NW'(MAX_BIMODAL_BITS));
    k_bits  = hbp_pkg::clamp_bits({1'b0, cbits_r}, NW'(MAX_CHOOSER_BITS));
    sh_amt  = m_bits - n_bits;
    word    = in_pc[31:2];

    hist_mask = ~({HW{1'b1}} << n_bits);
    hist_cur  = hist_r & hist_mask;
    hist_ext  = HX_W'(hist_cur) << sh_amt;

    gi = (word[GW-1:0] & ~({GW{1'b1}} << m_bits)) ^ hist_ext[GW-1:0];
    bi = word[BW-1:0] & ~({BW{1'b1}} << mb_bits);
    ci = word[CW-1:0] & ~({CW{1'b1}} << k_bits);

    // shift the outcome into the top of the active history
    hist_shift = (hist_cur >> 1) | (HW'(in_branch_taken) << (n_bits - 1'b1));
    hist_new   = hist_shift & hist_mask;
  end

  // Advance history per accepted transaction, unless bimodal mode or zero history bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (in_acc && (mode_r != hbp_pkg::MODE_BIMODAL) && (n_bits != '0)) begin
      hist_r <= hist_new;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers: indexes and outcome while memories are read
  // --------------------------------------------------------------------------
  logic [GW-1:0] s1_gi_r;
  logic [BW-1:0] s1_bi_r;
  logic [CW-1:0] s1_ci_r;
  logic          s1_taken_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gi_r    <= gi;
      s1_bi_r    <= bi;
      s1_ci_r    <= ci;
      s1_taken_r <= in_branch_taken;
    end
  end

  // --------------------------------------------------------------------------
  // Counter memories
  // --------------------------------------------------------------------------
  hbp_pkg::ctr_t g_mem [2**GW];
  hbp_pkg::ctr_t b_mem [2**BW];
  hbp_pkg::ctr_t c_mem [2**CW];

  hbp_pkg::ctr_t g_rd_r, b_rd_r, c_rd_r;
  logic          g_we, b_we, c_we;
  logic [GW-1:0] g_wa;
  logic [BW-1:0] b_wa;
  logic [CW-1:0] c_wa;
  hbp_pkg::ctr_t g_wd, b_wd, c_wd;
  logic          g_upd, b_upd, c_upd;
  hbp_pkg::ctr_t g_new, b_new, c_new;

  // Select clearing-pass or update write
  always_comb begin
    g_we = clr_busy_r || g_upd;
    b_we = clr_busy_r || b_upd;
    c_we = clr_busy_r || c_upd;
    g_wa = clr_busy_r ? clr_cnt_r[GW-1:0] : s1_gi_r;
    b_wa = clr_busy_r ? clr_cnt_r[BW-1:0] : s1_bi_r;
    c_wa = clr_busy_r ? clr_cnt_r[CW-1:0] : s1_ci_r;
    g_wd = clr_busy_r ? hbp_pkg::PRED_CTR_INIT    : g_new;
    b_wd = clr_busy_r ? hbp_pkg::PRED_CTR_INIT    : b_new;
    c_wd = clr_busy_r ? hbp_pkg::CHOOSER_CTR_INIT : c_new;
  end

  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_wa] <= g_wd;
    if (in_acc) g_rd_r <= g_mem[gi];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[b_wa] <= b_wd;
    if (in_acc) b_rd_r <= b_mem[bi];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    if (in_acc) c_rd_r <= c_mem[ci];
  end

  // --------------------------------------------------------------------------
  // Forwarding: last update written to each table
  // --------------------------------------------------------------------------
  logic          fg_vld_r, fb_vld_r, fc_vld_r;
  logic [GW-1:0] fg_addr_r;
  logic [BW-1:0] fb_addr_r;
  logic [CW-1:0] fc_addr_r;
  hbp_pkg::ctr_t fg_data_r, fb_data_r, fc_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_vld_r <= 1'b0;
      fb_vld_r <= 1'b0;
      fc_vld_r <= 1'b0;
    end else begin
      if (g_upd) fg_vld_r <= 1'b1;
      if (b_upd) fb_vld_r <= 1'b1;
      if (c_upd) fc_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (g_upd) begin
      fg_addr_r <= s1_gi_r;
      fg_data_r <= g_new;
    end
    if (b_upd) begin
      fb_addr_r <= s1_bi_r;
      fb_data_r <= b_new;
    end
    if (c_upd) begin
      fc_addr_r <= s1_ci_r;
      fc_data_r <= c_new;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: predict and compute counter updates
  // --------------------------------------------------------------------------
  hbp_pkg::ctr_t g_cur, b_cur, c_cur;
  logic          g_pred, b_pred, pred;
  logic          g_ok, b_ok, use_g;

  always_comb begin
    g_cur = (fg_vld_r && (fg_addr_r == s1_gi_r)) ? fg_data_r : g_rd_r;
    b_cur = (fb_vld_r && (fb_addr_r == s1_bi_r)) ? fb_data_r : b_rd_r;
    c_cur = (fc_vld_r && (fc_addr_r == s1_ci_r)) ? fc_data_r : c_rd_r;

    g_pred = g_cur[1];
    b_pred = b_cur[1];
    g_ok   = (g_pred == s1_taken_r);
    b_ok   = (b_pred == s1_taken_r);

    g_new = hbp_pkg::sat_bump(g_cur, s1_taken_r);
    b_new = hbp_pkg::sat_bump(b_cur, s1_taken_r);
    c_new = hbp_pkg::sat_bump(c_cur, g_ok);

    unique case (mode_r)
      hbp_pkg::MODE_BIMODAL: begin
        use_g = 1'b0;
        c_upd = 1'b0;
      end
      hbp_pkg::MODE_GSHARE: begin
        use_g = 1'b1;
        c_upd = 1'b0;
      end
      default: begin
        use_g = c_cur[1];
        // move chooser only when exactly one predictor was right
        c_upd = s1_fire && (g_ok != b_ok);
      end
    endcase

    pred  = use_g ? g_pred : b_pred;
    g_upd = s1_fire && use_g;
    b_upd = s1_fire && !use_g;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic out_pred_r, out_misp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_pred_r <= pred;
      out_misp_r <= pred ^ s1_taken_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_taken = out_pred_r;
  assign out_mispredicted    = out_misp_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !clr_busy_r)
    else $error("transaction accepted during clearing pass");

  a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !out_valid_r))
    else $error("pipeline busy during clearing pass");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction lost before stage 1");

  a_no_write_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> (!g_upd && !b_upd && !c_upd))
    else $error("counter update while stage 1 is held");

  a_one_pred_update: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |-> $onehot({g_upd, b_upd}))
    else $error("not exactly one predictor table updated");

endmodule

`default_nettype wire

// File: bench/hybrid_branch_predictor_unit_test.sv
// ----------------------------------------------------------------------------
// hybrid_branch_predictor_unit_test
// Self-checking bench for the tournament branch predictor. A table of directed
// branches and register writes runs first, then randomized phases of branch
// traffic over changing table sizes, history lengths and modes. Every result
// is compared with a local model of the counter tables, chooser and history.
// ----------------------------------------------------------------------------
module hybrid_branch_predictor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int CALM_ITEMS    = 150;
  localparam int POOL_SIZE     = 12;
  localparam int DRAIN_CYCLES  = 4;
  localparam int N_ROWS        = 43;

  // Mode codes as register write data; all ones reaches the unused mode code
  localparam logic [hbp_pkg::CFG_DATA_W-1:0] MODE_DATA_GSHARE   = {2'b00, hbp_pkg::MODE_GSHARE};
  localparam logic [hbp_pkg::CFG_DATA_W-1:0] MODE_DATA_HYBRID   = {2'b00, hbp_pkg::MODE_HYBRID};
  localparam logic [hbp_pkg::CFG_DATA_W-1:0] MODE_DATA_ALL_ONES = 4'hF;

  typedef enum logic {ROW_WRITE, ROW_BRANCH} row_kind_t;
  typedef enum logic [1:0] {PAT_NOT_TAKEN, PAT_TAKEN, PAT_ALTERNATE, PAT_COIN} pattern_t;

  typedef struct {
    row_kind_t                       kind;
    logic [hbp_pkg::CFG_IDX_W-1:0]   idx;
    logic [hbp_pkg::CFG_DATA_W-1:0]  data;
    logic [31:0]                     pc;
    logic                            taken;
    logic                            typed;
    logic                            pred;
    logic                            mis;
  } stim_row_t;

  typedef struct {
    int   seq;
    logic pred;
    logic mis;
  } prediction_t;

  // Directed rows; typed results are the obvious ones right after reset
  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'hFFFF_FFFC, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_4000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_MODE, MODE_DATA_GSHARE, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_GSHARE_BITS, 4'd14, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_HISTORY_BITS, 4'd14, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h8000_0010, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_MODE, MODE_DATA_HYBRID, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_GSHARE_BITS, 4'd15, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_HISTORY_BITS, 4'd15, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_BIMODAL_BITS, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_CHOOSER_BITS, 4'd15, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_FFF0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_FFF0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_FFF0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_FFF0, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_MODE, MODE_DATA_ALL_ONES, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_HISTORY_BITS, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0400, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0400, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_GSHARE_BITS, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_HISTORY_BITS, 4'd5, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_CHOOSER_BITS, 4'd0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h7FFF_FFFC, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_MODE, MODE_DATA_HYBRID, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_GSHARE_BITS, 4'd6, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_HISTORY_BITS, 4'd3, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_BIMODAL_BITS, 4'd4, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_CHOOSER_BITS, 4'd2, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0044, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0048, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0044, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, hbp_pkg::CFG_HISTORY_BITS, 4'd2, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0044, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_0048, 1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_BRANCH, hbp_pkg::CFG_MODE, 4'd0, 32'h0000_004C, 1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [31:0]                    in_pc = '0;
  logic                           in_branch_taken = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_predicted_taken;
  logic                           out_mispredicted;
  logic                           cfg_we = 1'b0;
  logic [hbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hbp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the predictor state and registers
  hbp_pkg::ctr_t              gsh_tab [1 << hbp_pkg::MAX_GSHARE_BITS_DEF];
  hbp_pkg::ctr_t              bim_tab [1 << hbp_pkg::MAX_BIMODAL_BITS_DEF];
  hbp_pkg::ctr_t              chs_tab [1 << hbp_pkg::MAX_CHOOSER_BITS_DEF];
  logic [hbp_pkg::HIST_W-1:0] ghist;
  logic [1:0]                 mode_r;
  logic [3:0]                 gsh_bits_r, hist_bits_r, bim_bits_r, chs_bits_r;

  prediction_t   predictions_due [$];
  logic [1:0]    typed_results [int];
  int            n_accepted = 0;
  int            n_sent = 0;
  int            n_errs = 0;
  int            n_writes = 0;
  int            n_mispredicts = 0;
  int            n_checked = 0;
  int            cycles = 0;
  int            in_gap_pct = 0;
  int            out_stall_pct = 0;
  int            stall_left = 0;

  hybrid_branch_predictor_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pc               (in_pc),
    .in_branch_taken     (in_branch_taken),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_taken (out_predicted_taken),
    .out_mispredicted    (out_mispredicted),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturating step of a 2-bit counter toward taken or not taken
  function automatic hbp_pkg::ctr_t step_ctr(hbp_pkg::ctr_t c, logic up);
    if (up) return (c == 2'd3) ? c : c + 2'd1;
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  // Queue one expected result behind the ones already due
  function automatic void note_prediction(input prediction_t p);
    predictions_due.insert(predictions_due.size(), p);
  endfunction

  // Predict one resolved branch and advance the tables and history
  function automatic logic predict_branch(input logic [31:0] pc, input logic taken);
    logic [29:0] word;
    int unsigned m, n, mb, k, hist, gi, bi, ci;
    logic        g_pred, b_pred, pred;
    word = pc[31:2];
    m  = (gsh_bits_r > hbp_pkg::MAX_GSHARE_BITS_DEF) ?
         hbp_pkg::MAX_GSHARE_BITS_DEF : gsh_bits_r;
    n  = (hist_bits_r > m) ? m : hist_bits_r;
    mb = (bim_bits_r > hbp_pkg::MAX_BIMODAL_BITS_DEF) ?
         hbp_pkg::MAX_BIMODAL_BITS_DEF : bim_bits_r;
    k  = (chs_bits_r > hbp_pkg::MAX_CHOOSER_BITS_DEF) ?
         hbp_pkg::MAX_CHOOSER_BITS_DEF : chs_bits_r;
    hist = ghist & ((1 << n) - 1);
    gi = (word & ((1 << m) - 1)) ^ (hist << (m - n));
    bi = word & ((1 << mb) - 1);
    ci = word & ((1 << k) - 1);
    g_pred = gsh_tab[gi][1];
    b_pred = bim_tab[bi][1];
    case (mode_r)
      hbp_pkg::MODE_BIMODAL: begin
        pred = b_pred;
        bim_tab[bi] = step_ctr(bim_tab[bi], taken);
      end
      hbp_pkg::MODE_GSHARE: begin
        pred = g_pred;
        gsh_tab[gi] = step_ctr(gsh_tab[gi], taken);
      end
      default: begin
        // Hybrid, and the spare code behaves the same
        if (chs_tab[ci][1]) begin
          pred = g_pred;
          gsh_tab[gi] = step_ctr(gsh_tab[gi], taken);
        end else begin
          pred = b_pred;
          bim_tab[bi] = step_ctr(bim_tab[bi], taken);
        end
        if (g_pred == taken && b_pred != taken) chs_tab[ci] = step_ctr(chs_tab[ci], 1'b1);
        else if (b_pred == taken && g_pred != taken) chs_tab[ci] = step_ctr(chs_tab[ci], 1'b0);
      end
    endcase
    // Shift the outcome into the top of the active history
    if (mode_r != hbp_pkg::MODE_BIMODAL && n > 0) begin
      hist  = ((hist >> 1) | (32'(taken) << (n - 1))) & ((1 << n) - 1);
      ghist = hist[hbp_pkg::HIST_W-1:0];
    end
    return pred;
  endfunction

  // Track accepted transactions, model them and check results in order
  always @(posedge clk) begin : track
    prediction_t head;
    logic        pred;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still due", cycles,
               predictions_due.size());
      $display("Some tests failed");
      $finish;
    end else if (!rst_n) begin
      foreach (gsh_tab[i]) gsh_tab[i] = hbp_pkg::PRED_CTR_INIT;
      foreach (bim_tab[i]) bim_tab[i] = hbp_pkg::PRED_CTR_INIT;
      foreach (chs_tab[i]) chs_tab[i] = hbp_pkg::CHOOSER_CTR_INIT;
      ghist       = '0;
      mode_r      = hbp_pkg::MODE_BIMODAL;
      gsh_bits_r  = hbp_pkg::GSHARE_BITS_RST;
      hist_bits_r = hbp_pkg::HISTORY_BITS_RST;
      bim_bits_r  = hbp_pkg::BIMODAL_BITS_RST;
      chs_bits_r  = hbp_pkg::CHOOSER_BITS_RST;
    end else begin
      // Check the result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (out_mispredicted === 1'b1) n_mispredicts++;
        if (predictions_due.size() == 0) begin
          $error("result transaction with no prediction due");
          n_errs++;
        end else begin
          head = predictions_due.pop_front();
          n_checked++;
          if (out_predicted_taken !== head.pred) begin
            $error("predicted_taken: expected %0b, actual %0b", head.pred,
                   out_predicted_taken);
            n_errs++;
          end
          if (out_mispredicted !== head.mis) begin
            $error("mispredicted: expected %0b, actual %0b", head.mis, out_mispredicted);
            n_errs++;
          end
          if (typed_results.exists(head.seq)) begin
            if (out_predicted_taken !== typed_results[head.seq][1]) begin
              $error("predicted_taken: expected %0b, actual %0b",
                     typed_results[head.seq][1], out_predicted_taken);
              n_errs++;
            end
            if (out_mispredicted !== typed_results[head.seq][0]) begin
              $error("mispredicted: expected %0b, actual %0b",
                     typed_results[head.seq][0], out_mispredicted);
              n_errs++;
            end
          end
        end
      end
      // Mirror register writes
      if (cfg_we) begin
        n_writes++;
        case (cfg_index)
          hbp_pkg::CFG_MODE:         mode_r      = cfg_wdata[1:0];
          hbp_pkg::CFG_GSHARE_BITS:  gsh_bits_r  = cfg_wdata;
          hbp_pkg::CFG_HISTORY_BITS: hist_bits_r = cfg_wdata;
          hbp_pkg::CFG_BIMODAL_BITS: bim_bits_r  = cfg_wdata;
          hbp_pkg::CFG_CHOOSER_BITS: chs_bits_r  = cfg_wdata;
          default: ;
        endcase
      end
      // Predict each accepted branch transaction
      if (in_valid && !in_stall) begin
        pred = predict_branch(in_pc, in_branch_taken);
        note_prediction('{n_accepted, pred, pred != in_branch_taken});
        n_accepted++;
      end
    end
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (rst_n && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Drive one branch transaction and hold it until accepted
  task automatic send_branch(input logic [31:0] pc, input logic taken);
    cfg_we          <= 1'b0;
    in_valid        <= 1'b1;
    in_pc           <= pc;
    in_branch_taken <= taken;
    do @(posedge clk); while (!(in_valid && !in_stall));
    n_sent++;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Write one register; the caller lowers the enable with its next transaction
  task automatic write_reg(input logic [hbp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hbp_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Wait until every result is back, the pipeline is empty and stalls are over
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    @(posedge clk);
    while (predictions_due.size() != 0 || stall_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] pool_pc   [POOL_SIZE];
    pattern_t    pool_pat  [POOL_SIZE];
    logic        pool_last [POOL_SIZE];
    logic [31:0] pc;
    logic        taken;
    int          phase, chunk, remaining, e, n_directed, total;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, light idling on both sides
    in_gap_pct    = 20;
    out_stall_pct = 20;
    n_directed    = 0;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        drain_pipeline();
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        if (dir_rows[r].typed)
          typed_results[n_sent] = {dir_rows[r].pred, dir_rows[r].mis};
        send_branch(dir_rows[r].pc, dir_rows[r].taken);
        n_directed++;
      end
    end

    // Random phases: new settings, then a burst of patterned branch traffic
    total = n_directed + RANDOM_ITEMS;
    phase = 0;
    while (n_sent < total) begin
      drain_pipeline();
      if (phase == 0) begin
        write_reg(hbp_pkg::CFG_MODE, MODE_DATA_HYBRID);
        write_reg(hbp_pkg::CFG_GSHARE_BITS, 4'd15);
        write_reg(hbp_pkg::CFG_HISTORY_BITS, 4'd15);
        write_reg(hbp_pkg::CFG_BIMODAL_BITS, 4'd15);
        write_reg(hbp_pkg::CFG_CHOOSER_BITS, 4'd15);
      end else if (phase == 1) begin
        write_reg(hbp_pkg::CFG_MODE, 4'($urandom_range(0, 3)));
        write_reg(hbp_pkg::CFG_GSHARE_BITS, 4'd0);
        write_reg(hbp_pkg::CFG_HISTORY_BITS, 4'd0);
        write_reg(hbp_pkg::CFG_BIMODAL_BITS, 4'd0);
        write_reg(hbp_pkg::CFG_CHOOSER_BITS, 4'd0);
      end else if (phase % 3 == 2) begin
        // Change only the history length, keeping tables and history warm
        write_reg(hbp_pkg::CFG_HISTORY_BITS, 4'($urandom_range(0, 15)));
      end else begin
        write_reg(hbp_pkg::CFG_MODE, 4'($urandom_range(0, 3)));
        write_reg(hbp_pkg::CFG_GSHARE_BITS, 4'($urandom_range(0, 15)));
        write_reg(hbp_pkg::CFG_HISTORY_BITS, 4'($urandom_range(0, 15)));
        write_reg(hbp_pkg::CFG_BIMODAL_BITS, 4'($urandom_range(0, 15)));
        write_reg(hbp_pkg::CFG_CHOOSER_BITS, 4'($urandom_range(0, 15)));
      end

      remaining = total - n_sent;
      if (remaining <= CALM_ITEMS) begin
        chunk         = remaining;
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        chunk = $urandom_range(40, 160);
        if (chunk > remaining - CALM_ITEMS) chunk = remaining - CALM_ITEMS;
        in_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end

      // Fresh branch sites, each with its own outcome pattern
      for (int i = 0; i < POOL_SIZE; i++) begin
        pool_pc[i]   = $urandom;
        pool_pat[i]  = pattern_t'($urandom_range(0, 3));
        pool_last[i] = 1'($urandom_range(0, 1));
      end

      repeat (chunk) begin
        if ($urandom_range(0, 9) < 7) begin
          e  = $urandom_range(0, POOL_SIZE - 1);
          pc = pool_pc[e];
          case (pool_pat[e])
            PAT_NOT_TAKEN: taken = 1'b0;
            PAT_TAKEN:     taken = 1'b1;
            PAT_ALTERNATE: taken = ~pool_last[e];
            default:       taken = 1'($urandom_range(0, 1));
          endcase
          pool_last[e] = taken;
        end else begin
          pc    = $urandom;
          taken = 1'($urandom_range(0, 1));
        end
        send_branch(pc, taken);
      end
      phase++;
    end

    // Let the last results come back
    drain_pipeline();
    $display("Covered %0d branches (%0d directed) over %0d register writes in %0d phases.",
             n_sent, n_directed, n_writes, phase);
    $display("Checked %0d results, %0d of them mispredicted; %0d mismatches.",
             n_checked, n_mispredicts, n_errs);
    if (n_errs == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/hbp_pkg.sv
hdl/hybrid_branch_predictor_unit.sv
bench/hybrid_branch_predictor_unit_test.sv
